[rtl/core/spc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spc_pkg
// Shared types and constants of the spectrum peak centroider.
// ----------------------------------------------------------------------------
package spc_pkg;

  // Fixed widths of the port fields.
  localparam int unsigned PORT_MZ_W    = 32;
  localparam int unsigned PORT_LEVEL_W = 32;
  localparam int unsigned AREA_W       = 63;

  // Width of one partial-product slice of the span.
  localparam int unsigned SLICE_W = 32;

  // Area saturates once the full product exceeds this many bits.
  localparam int unsigned SAT_SHIFT = 64;

  // Job queue between the classifier and the area pipeline.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = 2;
  localparam int unsigned QUEUE_CNT_W = 3;

  // Input point request.
  typedef struct packed {
    logic [PORT_MZ_W-1:0]    point_mz;
    logic [PORT_LEVEL_W-1:0] point_intensity;
    logic                    last_point;
  } point_t;

  // Result request.
  typedef struct packed {
    logic [PORT_MZ_W-1:0] centroid_mz;
    logic [AREA_W-1:0]    centroid_area;
  } centroid_t;

endpackage : spc_pkg
`default_nettype wire

[rtl/core/spc_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spc_front
// Streaming classifier: tracks neighbors and rise starts, finds apexes and
// their high corners, and issues one area job per kept peak.
// ----------------------------------------------------------------------------
module spc_front #(
  parameter int unsigned MZ_BITS    = 32,
  parameter int unsigned LEVEL_BITS = 32,
  parameter int unsigned JOB_W      = 3 * MZ_BITS + LEVEL_BITS
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire spc_pkg::point_t in_data,
  input  wire logic            accept,
  output logic                 job_push,
  output logic [JOB_W-1:0]     job_data
);

  logic [MZ_BITS-1:0]    mz;
  logic [LEVEL_BITS-1:0] lvl;
  logic                  last;

  logic [1:0]            seen_r,        seen_nxt;
  logic [MZ_BITS-1:0]    prev_mz_r,     prev_mz_nxt;
  logic [LEVEL_BITS-1:0] prev_level_r,  prev_level_nxt;
  logic [LEVEL_BITS-1:0] bp_level_r,    bp_level_nxt;
  logic [MZ_BITS-1:0]    rise_mz_r,     rise_mz_nxt;
  logic                  pending_r,     pending_nxt;
  logic [MZ_BITS-1:0]    apex_mz_r,     apex_mz_nxt;
  logic [LEVEL_BITS-1:0] apex_level_r,  apex_level_nxt;
  logic [MZ_BITS-1:0]    apex_low_r,    apex_low_nxt;

  logic pend_fire, pend_emit, is_apex, apex_check, ends_now, apex_emit, apex_hold;

  assign mz   = MZ_BITS'(in_data.point_mz);
  assign lvl  = LEVEL_BITS'(in_data.point_intensity);
  assign last = in_data.last_point;

  // A pending descent ends here; a negative area is dropped.
  assign pend_fire = pending_r && ((lvl == '0) || (lvl >= prev_level_r) || last);
  assign pend_emit = pend_fire && (mz >= apex_low_r);

  // The previous point is a strict local maximum that is not flanked by zeros.
  assign is_apex = (seen_r >= 2'd2) && (bp_level_r < prev_level_r) &&
                   (lvl < prev_level_r) && !((bp_level_r == '0) && (lvl == '0));
  assign apex_check = !pend_emit && is_apex;
  assign ends_now   = (lvl == '0) || last;
  assign apex_emit  = apex_check && ends_now && (mz >= rise_mz_r);
  assign apex_hold  = apex_check && !ends_now;

  // Job: apex m/z, low corner, high corner, apex intensity.
  assign job_push = accept && (pend_emit || apex_emit);
  assign job_data = pend_emit ? {apex_mz_r, apex_low_r, mz, apex_level_r}
                              : {prev_mz_r, rise_mz_r, mz, prev_level_r};

  // Next state for an accepted point.
  always_comb begin
    seen_nxt       = seen_r;
    prev_mz_nxt    = prev_mz_r;
    prev_level_nxt = prev_level_r;
    bp_level_nxt   = bp_level_r;
    rise_mz_nxt    = rise_mz_r;
    pending_nxt    = pending_r;
    apex_mz_nxt    = apex_mz_r;
    apex_level_nxt = apex_level_r;
    apex_low_nxt   = apex_low_r;
    if (accept) begin
      if (last) begin
        seen_nxt       = '0;
        prev_mz_nxt    = '0;
        prev_level_nxt = '0;
        bp_level_nxt   = '0;
        rise_mz_nxt    = '0;
        pending_nxt    = 1'b0;
        apex_mz_nxt    = '0;
        apex_level_nxt = '0;
        apex_low_nxt   = '0;
      end else begin
        if (pend_fire) begin
          pending_nxt = 1'b0;
        end
        if (apex_hold) begin
          pending_nxt    = 1'b1;
          apex_mz_nxt    = prev_mz_r;
          apex_level_nxt = prev_level_r;
          apex_low_nxt   = rise_mz_r;
        end
        // The rise restarts at the previous point unless it was still climbing.
        if ((seen_r != 2'd0) &&
            ((seen_r == 2'd1) || (prev_level_r == '0) || (prev_level_r >= lvl))) begin
          rise_mz_nxt = prev_mz_r;
        end
        bp_level_nxt   = prev_level_r;
        prev_level_nxt = lvl;
        prev_mz_nxt    = mz;
        if (seen_r != 2'd2) begin
          seen_nxt = seen_r + 2'd1;
        end
      end
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r       <= '0;
      prev_mz_r    <= '0;
      prev_level_r <= '0;
      bp_level_r   <= '0;
      rise_mz_r    <= '0;
      pending_r    <= 1'b0;
      apex_mz_r    <= '0;
      apex_level_r <= '0;
      apex_low_r   <= '0;
    end else begin
      seen_r       <= seen_nxt;
      prev_mz_r    <= prev_mz_nxt;
      prev_level_r <= prev_level_nxt;
      bp_level_r   <= bp_level_nxt;
      rise_mz_r    <= rise_mz_nxt;
      pending_r    <= pending_nxt;
      apex_mz_r    <= apex_mz_nxt;
      apex_level_r <= apex_level_nxt;
      apex_low_r   <= apex_low_nxt;
    end
  end

endmodule : spc_front
`default_nettype wire

[rtl/core/spc_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spc_queue
// Small first-in first-out job queue that decouples classifier and pipeline.
// ----------------------------------------------------------------------------
module spc_queue #(
  parameter int unsigned DATA_W = 128
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire logic [DATA_W-1:0] push_data,
  output logic                   not_full,
  input  wire logic              pop,
  output logic                   not_empty,
  output logic [DATA_W-1:0]      pop_data
);

  logic [DATA_W-1:0]               slot_r [spc_pkg::QUEUE_DEPTH];
  logic [spc_pkg::QUEUE_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [spc_pkg::QUEUE_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [spc_pkg::QUEUE_CNT_W-1:0] count_r,  count_nxt;
  logic                            do_push, do_pop;

  assign not_full  = (count_r != spc_pkg::QUEUE_CNT_W'(spc_pkg::QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = slot_r[rd_ptr_r];
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage slots.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule : spc_queue
`default_nettype wire

[rtl/core/spc_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spc_back
// Area pipeline: span subtract, sliced multiply, combine and saturate,
// then the result register.
// ----------------------------------------------------------------------------
module spc_back #(
  parameter int unsigned MZ_BITS    = 32,
  parameter int unsigned LEVEL_BITS = 32,
  parameter int unsigned JOB_W      = 3 * MZ_BITS + LEVEL_BITS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               job_valid,
  input  wire logic [JOB_W-1:0]   job_data,
  output logic                    job_pop,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output spc_pkg::centroid_t      out_data
);

  localparam int unsigned LO_W   = (MZ_BITS > spc_pkg::SLICE_W) ? spc_pkg::SLICE_W : MZ_BITS;
  localparam int unsigned HI_W   = (MZ_BITS > spc_pkg::SLICE_W) ?
                                   (MZ_BITS - spc_pkg::SLICE_W) : 1;
  localparam int unsigned P0_W   = LO_W + LEVEL_BITS;
  localparam int unsigned P1_W   = HI_W + LEVEL_BITS;
  localparam int unsigned PROD_W = MZ_BITS + LEVEL_BITS + 1;

  logic [MZ_BITS-1:0]    j_mz, j_low, j_high;
  logic [LEVEL_BITS-1:0] j_level;
  logic                  advance;

  logic                  s1_valid_r;
  logic [MZ_BITS-1:0]    s1_mz_r;
  logic [MZ_BITS-1:0]    s1_span_r;
  logic [LEVEL_BITS-1:0] s1_level_r;

  logic                  s2_valid_r;
  logic [MZ_BITS-1:0]    s2_mz_r;
  logic [P0_W-1:0]       s2_p0_r;
  logic [P1_W-1:0]       s2_p1_r;

  logic                  out_valid_r;
  spc_pkg::centroid_t    out_data_r;

  logic [LO_W-1:0]       span_lo;
  logic [HI_W-1:0]       span_hi;
  logic [PROD_W-1:0]     full_prod;
  logic                  saturate;

  assign {j_mz, j_low, j_high, j_level} = job_data;

  // The whole pipeline moves whenever the result register can take a request.
  assign advance = !out_valid_r || out_ready;
  assign job_pop = advance && job_valid;

  // Span slices for the partial products.
  assign span_lo = s1_span_r[LO_W-1:0];
  if (MZ_BITS > spc_pkg::SLICE_W) begin : g_hi_slice
    assign span_hi = s1_span_r[MZ_BITS-1:spc_pkg::SLICE_W];
  end else begin : g_no_hi_slice
    assign span_hi = '0;
  end

  // Recombine the slices and saturate above 63 bits.
  assign full_prod = (PROD_W'(s2_p1_r) << spc_pkg::SLICE_W) + PROD_W'(s2_p0_r);
  assign saturate  = ((full_prod >> spc_pkg::SAT_SHIFT) != '0);

  // Valid bits of the stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r  <= job_valid;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_mz_r    <= j_mz;
      s1_span_r  <= j_high - j_low;
      s1_level_r <= j_level;
      s2_mz_r    <= s1_mz_r;
      s2_p0_r    <= P0_W'(span_lo) * P0_W'(s1_level_r);
      s2_p1_r    <= P1_W'(span_hi) * P1_W'(s1_level_r);
      out_data_r.centroid_mz   <= spc_pkg::PORT_MZ_W'(s2_mz_r);
      out_data_r.centroid_area <= saturate ? {spc_pkg::AREA_W{1'b1}}
                                           : spc_pkg::AREA_W'(full_prod >> 1);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule : spc_back
`default_nettype wire

[rtl/core/spectrum_peak_centroider.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spectrum_peak_centroider
// Local-maximum peak centroider for a stream of spectrum points.
//
//   Channel  Direction  Handshake              Payload
//   in_      input      in_valid / in_ready    spc_pkg::point_t
//   out_     output     out_valid / out_ready  spc_pkg::centroid_t
//
// One point is taken every cycle while the job queue has room; the classifier
// updates its neighbor state in the cycle of acceptance, so it never holds up
// the stream by itself. A peak result goes from the point that closes its descent
// through the job queue, span stage, partial-product stage and result register.
// Synchronous active-low reset clears the classifier, queue and stage valids.
// When results are not taken, the pipeline holds and the four-entry job
// queue absorbs peaks; in_ready drops only once that queue is full.
// ----------------------------------------------------------------------------
module spectrum_peak_centroider #(
  parameter int unsigned MZ_BITS    = 32,
  parameter int unsigned LEVEL_BITS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire spc_pkg::point_t    in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output spc_pkg::centroid_t      out_data
);

  localparam int unsigned JOB_W = 3 * MZ_BITS + LEVEL_BITS;

  logic             accept;
  logic             job_push;
  logic [JOB_W-1:0] push_data;
  logic             q_not_full;
  logic             q_not_empty;
  logic             job_pop;
  logic [JOB_W-1:0] pop_data;

  assign in_ready = q_not_full;
  assign accept   = in_valid && q_not_full;

  // Classifier.
  spc_front #(
    .MZ_BITS    (MZ_BITS),
    .LEVEL_BITS (LEVEL_BITS),
    .JOB_W      (JOB_W)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .accept   (accept),
    .job_push (job_push),
    .job_data (push_data)
  );

  // Job queue.
  spc_queue #(
    .DATA_W (JOB_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data (push_data),
    .not_full  (q_not_full),
    .pop       (job_pop),
    .not_empty (q_not_empty),
    .pop_data  (pop_data)
  );

  // Area pipeline.
  spc_back #(
    .MZ_BITS    (MZ_BITS),
    .LEVEL_BITS (LEVEL_BITS),
    .JOB_W      (JOB_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (q_not_empty),
    .job_data  (pop_data),
    .job_pop   (job_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule : spectrum_peak_centroider
`default_nettype wire

[dv/spectrum_peak_centroider_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spectrum_peak_centroider_checker
// Watches both channels of the peak centroider and checks every result. Each
// accepted point goes through a cycle-free model of the peak finder, and the
// centroids it predicts wait in order until the block returns them.
// ----------------------------------------------------------------------------
module spectrum_peak_centroider_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  spc_pkg::point_t    in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  spc_pkg::centroid_t out_data,
  output int unsigned        fail_count,
  output int unsigned        pending_count
);

  localparam int unsigned REPORT_LIMIT = 10;

  // Centroids predicted but not yet returned, oldest first.
  spc_pkg::centroid_t centroid_q[$];
  spc_pkg::centroid_t oldest_centroid;

  // Neighbor state of the peak finder.
  logic [1:0]                       pts_seen;
  logic [spc_pkg::PORT_MZ_W-1:0]    last_mz;
  logic [spc_pkg::PORT_LEVEL_W-1:0] last_level;
  logic [spc_pkg::PORT_LEVEL_W-1:0] older_level;
  logic [spc_pkg::PORT_MZ_W-1:0]    rise_mz;

  // A peak whose descent has not ended yet.
  logic                             descent_open;
  logic [spc_pkg::PORT_MZ_W-1:0]    peak_mz;
  logic [spc_pkg::PORT_LEVEL_W-1:0] peak_level;
  logic [spc_pkg::PORT_MZ_W-1:0]    peak_low_mz;

  task automatic clear_peak_state();
    pts_seen     = '0;
    last_mz      = '0;
    last_level   = '0;
    older_level  = '0;
    rise_mz      = '0;
    descent_open = 1'b0;
    peak_mz      = '0;
    peak_level   = '0;
    peak_low_mz  = '0;
  endtask

  // Queues the triangle area of a peak unless its corners are reversed.
  task automatic close_peak(input logic [spc_pkg::PORT_MZ_W-1:0] apex_mz,
                            input logic [spc_pkg::PORT_MZ_W-1:0] low_mz,
                            input logic [spc_pkg::PORT_MZ_W-1:0] high_mz,
                            input logic [spc_pkg::PORT_LEVEL_W-1:0] level,
                            output bit emitted);
    logic [spc_pkg::PORT_MZ_W-1:0] span;
    logic [63:0]                   product;
    spc_pkg::centroid_t            centroid;
    emitted = (high_mz >= low_mz);
    if (emitted) begin
      span                   = high_mz - low_mz;
      product                = {32'b0, span} * {32'b0, level};
      centroid.centroid_mz   = apex_mz;
      centroid.centroid_area = product[63:1];
      centroid_q.insert(centroid_q.size(), centroid);
    end
  endtask

  // Advances the peak finder by one point.
  task automatic predict_point(input spc_pkg::point_t p);
    logic [spc_pkg::PORT_MZ_W-1:0]    mz;
    logic [spc_pkg::PORT_LEVEL_W-1:0] level;
    logic                             last;
    bit                               emitted;
    mz      = p.point_mz;
    level   = p.point_intensity;
    last    = p.last_point;
    emitted = 1'b0;

    // An open descent ends on a zero, a non-falling point or the final point.
    if (descent_open && (level == '0 || level >= last_level || last)) begin
      close_peak(peak_mz, peak_low_mz, mz, peak_level, emitted);
      descent_open = 1'b0;
    end

    // The previous point is a peak when strictly above both neighbors,
    // unless both neighbors are zero.
    if (!emitted && pts_seen >= 2'd2 && older_level < last_level &&
        level < last_level && !(older_level == '0 && level == '0)) begin
      if (level == '0 || last) begin
        close_peak(last_mz, rise_mz, mz, last_level, emitted);
      end else begin
        descent_open = 1'b1;
        peak_mz      = last_mz;
        peak_level   = last_level;
        peak_low_mz  = rise_mz;
      end
    end

    // The rise toward the previous point starts there unless it climbed.
    if (pts_seen == 2'd1 ||
        (pts_seen >= 2'd2 && (last_level == '0 || last_level >= level))) begin
      rise_mz = last_mz;
    end

    older_level = last_level;
    last_level  = level;
    last_mz     = mz;
    if (pts_seen < 2'd2) begin
      pts_seen = pts_seen + 2'd1;
    end

    // The final point of a spectrum returns everything to reset.
    if (last) begin
      clear_peak_state();
    end
  endtask

  // Requests are taken first so that a result never overtakes its point.
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_peak_state();
      centroid_q.delete();
      fail_count = 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_point(in_data);
      end
      if (out_valid && out_ready) begin
        if (centroid_q.size() == 0) begin
          if (fail_count < REPORT_LIMIT) begin
            $display("%0t: unexpected centroid mz=%h area=%h", $time,
                     out_data.centroid_mz, out_data.centroid_area);
          end
          fail_count++;
        end else begin
          oldest_centroid = centroid_q.pop_front();
          if (out_data.centroid_mz !== oldest_centroid.centroid_mz ||
              out_data.centroid_area !== oldest_centroid.centroid_area) begin
            if (fail_count < REPORT_LIMIT) begin
              $display("%0t: centroid mismatch mz exp=%h got=%h, area exp=%h got=%h",
                       $time, oldest_centroid.centroid_mz, out_data.centroid_mz,
                       oldest_centroid.centroid_area, out_data.centroid_area);
            end
            fail_count++;
          end
        end
      end
    end
    pending_count <= centroid_q.size();
  end

endmodule : spectrum_peak_centroider_checker

[dv/spectrum_peak_centroider_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spectrum_peak_centroider_tb
// Drives spectra into the peak centroider: a short directed set of peak
// shapes and corner values, then random spectra with bursty input and a
// stalling receiver. The checker instance judges every centroid.
// ----------------------------------------------------------------------------
module spectrum_peak_centroider_tb;

  localparam int unsigned POINT_TARGET = 750;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 32;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  spc_pkg::point_t    in_data;
  logic               out_valid;
  logic               out_ready = 1'b0;
  spc_pkg::centroid_t out_data;
  int unsigned        fail_count;
  int unsigned        pending_count;

  int unsigned cycle_count  = 0;
  int unsigned points_sent  = 0;
  int unsigned burst_left   = 0;
  logic [15:0] ready_pattern = 16'hFFFF;
  int unsigned ready_hold    = 0;

  spectrum_peak_centroider i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  spectrum_peak_centroider_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Receiver: a rotating ready pattern, replaced by a new random one whenever its hold count runs out.
  always @(posedge clk) begin
    if (ready_hold == 0) begin
      case ($urandom_range(0, 3))
        0:       ready_pattern <= 16'hFFFF;
        1:       ready_pattern <= 16'($urandom) | 16'h0001;
        default: ready_pattern <= 16'($urandom & $urandom) | 16'h0001;
      endcase
      ready_hold <= $urandom_range(32, 200);
    end else begin
      ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
      ready_hold    <= ready_hold - 1;
    end
    out_ready <= ready_pattern[0];
  end

  function automatic spc_pkg::point_t pt(input logic [31:0] mz, input logic [31:0] level,
                                         input logic last);
    spc_pkg::point_t p;
    p.point_mz        = mz;
    p.point_intensity = level;
    p.last_point      = last;
    return p;
  endfunction

  // Sends one point, opening a new burst after a random gap when due.
  task automatic send_point(input spc_pkg::point_t p);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    points_sent++;
  endtask

  // A spectrum of random points: any bits, the last flag at random.
  task automatic send_noise_spectrum();
    int unsigned len;
    len = $urandom_range(1, 6);
    for (int unsigned i = 0; i < len; i++) begin
      send_point(pt($urandom, $urandom, $urandom_range(0, 3) == 0));
    end
  endtask

  // A spectrum with rising and falling runs, zeros and plateaus.
  task automatic send_shaped_spectrum();
    int unsigned len;
    logic [31:0] mz;
    logic [63:0] level;
    logic [63:0] ceiling;
    logic [63:0] step;
    bit          rising;
    bit          falling_mz;
    len        = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60)
                                               : $urandom_range(2, 16);
    mz         = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h00FF_FFFF);
    ceiling    = ($urandom_range(0, 4) == 0) ? 64'hFFFF_FFFF : 64'($urandom_range(20, 4000));
    falling_mz = ($urandom_range(0, 9) == 0);
    level      = 64'($urandom_range(0, 5));
    rising     = 1'b1;
    for (int unsigned i = 0; i < len; i++) begin
      case ($urandom_range(0, 15))
        0, 1: level = '0;
        2: ;
        default: begin
          if ($urandom_range(0, 3) == 0) begin
            rising = !rising;
          end
          step = 64'($urandom_range(1, 32'(ceiling / 4) + 1));
          if (rising) begin
            level = (level + step > ceiling) ? ceiling : level + step;
          end else begin
            level = (level > step) ? level - step : '0;
          end
        end
      endcase
      send_point(pt(mz, level[31:0], i == len - 1));
      if (falling_mz) begin
        mz = mz - $urandom_range(0, 3000);
      end else begin
        mz = mz + $urandom_range(0, 3000);
      end
    end
  endtask

  initial begin
    spc_pkg::point_t directed[$];
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    directed = '{
      // Single-point spectrum.
      pt(32'h0001_0000, 32'd50, 1'b1),
      // Apex on the first point: no result.
      pt(32'd10, 32'd9, 1'b0), pt(32'd11, 32'd3, 1'b0), pt(32'd12, 32'd1, 1'b1),
      // Both neighbors zero: the maximum is skipped.
      pt(32'd1, 32'd0, 1'b0), pt(32'd2, 32'd9, 1'b0), pt(32'd3, 32'd0, 1'b1),
      // Descent ending on a zero, on a rising point, and on the final point.
      pt(32'h0001_0000, 32'd2, 1'b0), pt(32'h0002_0000, 32'd10, 1'b0),
      pt(32'h0003_0000, 32'd0, 1'b0), pt(32'h0004_0000, 32'd3, 1'b0),
      pt(32'h0005_0000, 32'd9, 1'b0), pt(32'h0006_0000, 32'd5, 1'b0),
      pt(32'h0007_0000, 32'd6, 1'b0), pt(32'h0008_0000, 32'd2, 1'b0),
      pt(32'h0009_0000, 32'd1, 1'b1),
      // Low corner above high corner: the peak is dropped.
      pt(32'd100, 32'd1, 1'b0), pt(32'd50, 32'd9, 1'b0), pt(32'd10, 32'd0, 1'b1),
      // Equal corners: zero area.
      pt(32'd7, 32'd1, 1'b0), pt(32'd8, 32'd9, 1'b0), pt(32'd7, 32'd0, 1'b1),
      // Largest span and intensity.
      pt(32'h0000_0000, 32'd1, 1'b0), pt(32'h8000_0000, 32'hFFFF_FFFF, 1'b0),
      pt(32'hFFFF_FFFF, 32'd0, 1'b1)
    };
    foreach (directed[i]) begin
      send_point(directed[i]);
    end

    // Mostly well-formed spectra, with some noise in between.
    while (points_sent < POINT_TARGET) begin
      if ($urandom_range(0, 7) == 0) begin
        send_noise_spectrum();
      end else begin
        send_shaped_spectrum();
      end
    end
    in_valid <= 1'b0;

    // Let the last expectation land, then wait for every centroid.
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("status: fail");
    $finish;
  end

endmodule : spectrum_peak_centroider_tb
